// File: sv/button_autorepeat_updown_counter_defines.svh
// Assertion macros for the button autorepeat counter checker.
// Expects signals named clock and reset in the using scope.
`ifndef BUTTON_AUTOREPEAT_UPDOWN_COUNTER_DEFINES_SVH
`define BUTTON_AUTOREPEAT_UPDOWN_COUNTER_DEFINES_SVH

// Clocked check, off while reset is high.
`define BAUC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds through reset.
`define BAUC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: sv/bauc_pkg.sv
// Shared types and constants for the button autorepeat up/down counter.
// No dependencies.
`default_nettype none

package bauc_pkg;

   localparam int VALUE_BITS_DEF = 7;
   localparam int HOLD_BITS_DEF  = 16;

   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam int PERIOD_BITS   = 8;
   localparam int CFG_HOLD_BITS = 16;

   localparam logic [CFG_HOLD_BITS-1:0] SHORT_HOLD_RST  = 16'd100;
   localparam logic [CFG_HOLD_BITS-1:0] LONG_HOLD_RST   = 16'd300;
   localparam logic [PERIOD_BITS-1:0]   SLOW_REPEAT_RST = 8'd50;
   localparam logic [PERIOD_BITS-1:0]   FAST_REPEAT_RST = 8'd10;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_SHORT_HOLD  = 2'd0,
      CSR_LONG_HOLD   = 2'd1,
      CSR_SLOW_REPEAT = 2'd2,
      CSR_FAST_REPEAT = 2'd3
   } csr_addr_type;

   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_UP_PRESS = 3'd1,
      MODE_UP_SLOW  = 3'd2,
      MODE_UP_FAST  = 3'd3,
      MODE_DN_PRESS = 3'd4,
      MODE_DN_SLOW  = 3'd5,
      MODE_DN_FAST  = 3'd6
   } mode_type;

   typedef struct packed {
      logic [CFG_HOLD_BITS-1:0] short_hold;
      logic [CFG_HOLD_BITS-1:0] long_hold;
      logic [PERIOD_BITS-1:0]   slow_repeat;
      logic [PERIOD_BITS-1:0]   fast_repeat;
   } cfg_type;

   // Per-button status after the current tick, plus the sample before it.
   typedef struct packed {
      logic                   prev_level;   // stored sample before this tick
      logic                   pressed;
      logic                   short_hit;
      logic                   long_hit;
      logic [PERIOD_BITS-1:0] phase;
      logic                   clr_step;     // phase reached period - 1 this tick
   } btn_stat_type;

endpackage

`default_nettype wire

// File: sv/button_autorepeat_updown_counter.sv
// Debounced up/down push-button counter with two-speed autorepeat.
// A request passes through the input register, then the result register, to its response.
// Throughput: one request per cycle while the response channel is not stalled.
// Reset (synchronous, active high): counter 0, mode idle, buttons released,
// both stages empty, timing registers back to 100/300/50/10 ticks.
`default_nettype none

module button_autorepeat_updown_counter
   import bauc_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int HOLD_BITS  = HOLD_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel: one timer tick
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [7:0]                         req_tdata,  // [0] up_level, [1] down_level
   // response channel: counter after the tick
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [((VALUE_BITS+8)/8)*8-1:0]         rsp_tdata,  // value, then changed
   // configuration writes
   input  wire logic                               csr_we,
   input  wire logic [CSR_ADDR_BITS-1:0]           csr_addr,
   input  wire logic [CSR_DATA_BITS-1:0]           csr_wdata
);

   localparam int RSP_BITS = ((VALUE_BITS + 8) / 8) * 8;

   // timing registers
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_hold  <= SHORT_HOLD_RST;
         cfg_ff.long_hold   <= LONG_HOLD_RST;
         cfg_ff.slow_repeat <= SLOW_REPEAT_RST;
         cfg_ff.fast_repeat <= FAST_REPEAT_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_SHORT_HOLD:  cfg_ff.short_hold  <= csr_wdata;
            CSR_LONG_HOLD:   cfg_ff.long_hold   <= csr_wdata;
            CSR_SLOW_REPEAT: cfg_ff.slow_repeat <= csr_wdata[PERIOD_BITS-1:0];
            CSR_FAST_REPEAT: cfg_ff.fast_repeat <= csr_wdata[PERIOD_BITS-1:0];
         endcase
      end
   end

   // Two-slot flow: the input register holds a tick while the result register
   // holds the previous response, so a stalled consumer never stops intake
   // until both are full.
   logic in_valid_ff, in_valid_in;
   logic up_ff, dn_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic changed_ff, changed_in;
   logic out_free, adv, req_take;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign adv        = in_valid_ff && out_free;      // tick processed this cycle
   assign req_tready = !in_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      if (req_take) in_valid_in = 1'b1;
      else if (adv) in_valid_in = 1'b0;
      else in_valid_in = in_valid_ff;
      if (adv) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         up_ff <= req_tdata[0];
         dn_ff <= req_tdata[1];
      end
      if (adv) begin
         value_ff   <= value_in;
         changed_ff <= changed_in;
      end
   end

   // Button trackers. Down is honored only while up's stored sample
   // (before this tick) shows released.
   btn_stat_type up_stat, dn_stat;

   bauc_button #(.HOLD_BITS(HOLD_BITS)) u_up_btn (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .sample (up_ff),
      .enable (1'b1),
      .cfg    (cfg_ff),
      .stat   (up_stat)
   );

   bauc_button #(.HOLD_BITS(HOLD_BITS)) u_dn_btn (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .sample (dn_ff),
      .enable (up_stat.prev_level),
      .cfg    (cfg_ff),
      .stat   (dn_stat)
   );

   bauc_ctrl #(.VALUE_BITS(VALUE_BITS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .up_stat    (up_stat),
      .dn_stat    (dn_stat),
      .cfg        (cfg_ff),
      .value_in   (value_in),
      .changed_in (changed_in)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_BITS'({changed_ff, value_ff});

endmodule

`default_nettype wire

// File: sv/bauc_button.sv
// One button: settle check, saturating hold count, repeat phase and flags.
// Depends on bauc_pkg.
`default_nettype none

module bauc_button
   import bauc_pkg::*;
#(
   parameter int HOLD_BITS = HOLD_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         adv,
   input  wire logic         sample,
   input  wire logic         enable,
   input  wire cfg_type      cfg,
   output btn_stat_type      stat
);

   localparam int CMP_BITS = (HOLD_BITS > CFG_HOLD_BITS) ? HOLD_BITS : CFG_HOLD_BITS;

   logic                   prev_ff, prev_in;
   logic [HOLD_BITS-1:0]   hold_ff, hold_in;
   logic [PERIOD_BITS-1:0] phase_ff, phase_in;
   logic [2:0]             flags_ff, flags_in;

   logic [HOLD_BITS-1:0]   hold_inc;
   logic [CMP_BITS-1:0]    hold_cmp;
   logic                   at_short, at_long;
   logic [PERIOD_BITS-1:0] period, phase_p1;
   logic                   clr_step;

   always_comb begin
      hold_inc = (&hold_ff) ? hold_ff : hold_ff + 1'b1;
      hold_cmp = CMP_BITS'(hold_inc);
      at_long  = hold_cmp >= CMP_BITS'(cfg.long_hold);
      at_short = (hold_cmp >= CMP_BITS'(cfg.short_hold)) && !at_long;
      period   = at_long ? cfg.fast_repeat : cfg.slow_repeat;
      phase_p1 = phase_ff + 1'b1;
   end

   always_comb begin
      prev_in  = sample;
      hold_in  = hold_ff;
      phase_in = phase_ff;
      flags_in = flags_ff;
      clr_step = 1'b0;
      if (prev_ff == sample) begin
         if (!sample && enable) begin
            hold_in     = hold_inc;
            flags_in[0] = 1'b1;
            if (at_short || at_long) begin
               if (at_short) begin
                  flags_in[1] = 1'b1;
               end else begin
                  flags_in[2] = 1'b1;
               end
               clr_step = phase_p1 == (period - 1'b1);
               phase_in = (phase_p1 >= period) ? '0 : phase_p1;
            end
         end else begin
            hold_in  = '0;
            phase_in = '0;
            flags_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= 1'b1;
         hold_ff  <= '0;
         phase_ff <= '0;
         flags_ff <= '0;
      end else if (adv) begin
         prev_ff  <= prev_in;
         hold_ff  <= hold_in;
         phase_ff <= phase_in;
         flags_ff <= flags_in;
      end
   end

   assign stat.prev_level = prev_ff;
   assign stat.pressed    = flags_in[0];
   assign stat.short_hit  = flags_in[1];
   assign stat.long_hit   = flags_in[2];
   assign stat.phase      = phase_in;
   assign stat.clr_step   = clr_step;

endmodule

`default_nettype wire

// File: sv/bauc_ctrl.sv
// Mode state machine, repeat step gating and the wrapping up/down counter.
// Depends on bauc_pkg.
`default_nettype none

module bauc_ctrl
   import bauc_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire btn_stat_type          up_stat,
   input  wire btn_stat_type          dn_stat,
   input  wire cfg_type               cfg,
   output logic [VALUE_BITS-1:0]      value_in,
   output logic                       changed_in
);

   mode_type               mode_ff, mode_in;
   logic                   step_done_ff, step_done_in;
   logic [VALUE_BITS-1:0]  counter_ff;
   logic                   done_now;
   logic                   up_slow_due, up_fast_due, dn_slow_due, dn_fast_due;
   logic                   inc, dec;

   // Either button's phase passing period - 1 re-arms the repeat step.
   always_comb begin
      done_now    = step_done_ff && !up_stat.clr_step && !dn_stat.clr_step;
      up_slow_due = (up_stat.phase == cfg.slow_repeat - 1'b1) && !done_now;
      up_fast_due = (up_stat.phase == cfg.fast_repeat - 1'b1) && !done_now;
      dn_slow_due = (dn_stat.phase == cfg.slow_repeat - 1'b1) && !done_now;
      dn_fast_due = (dn_stat.phase == cfg.fast_repeat - 1'b1) && !done_now;
   end

   // Next state
   always_comb begin
      mode_in = mode_ff;
      unique case (mode_ff)
         MODE_UP_PRESS: begin
            if (!up_stat.pressed) mode_in = MODE_IDLE;
            else if (up_stat.short_hit) mode_in = MODE_UP_SLOW;
         end
         MODE_UP_SLOW: begin
            if (!up_stat.pressed) mode_in = MODE_IDLE;
            else if (up_stat.long_hit) mode_in = MODE_UP_FAST;
         end
         MODE_UP_FAST: begin
            if (!up_fast_due && !up_stat.pressed) mode_in = MODE_IDLE;
         end
         MODE_DN_PRESS: begin
            if (!dn_stat.pressed) mode_in = MODE_IDLE;
            else if (dn_stat.short_hit) mode_in = MODE_DN_SLOW;
         end
         MODE_DN_SLOW: begin
            if (!dn_stat.pressed) mode_in = MODE_IDLE;
            else if (!dn_slow_due && dn_stat.long_hit) mode_in = MODE_DN_FAST;
         end
         MODE_DN_FAST: begin
            if (!dn_stat.pressed) mode_in = MODE_IDLE;
         end
         default: begin
            if (up_stat.pressed) mode_in = MODE_UP_PRESS;
            else if (dn_stat.pressed) mode_in = MODE_DN_PRESS;
            else mode_in = MODE_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      inc = 1'b0;
      dec = 1'b0;
      unique case (mode_ff)
         MODE_UP_PRESS: ;
         MODE_UP_SLOW:  inc = up_slow_due;
         MODE_UP_FAST:  inc = up_fast_due;
         MODE_DN_PRESS: ;
         MODE_DN_SLOW:  dec = dn_stat.pressed && dn_slow_due;
         MODE_DN_FAST:  dec = dn_stat.pressed && dn_fast_due;
         default: begin
            inc = up_stat.pressed;
            dec = !up_stat.pressed && dn_stat.pressed;
         end
      endcase
   end

   // A fresh press never sets step_done; only a repeat step does.
   always_comb begin
      step_done_in = done_now;
      if ((inc || dec) && mode_ff != MODE_IDLE && mode_ff != MODE_UP_PRESS
          && mode_ff != MODE_DN_PRESS) begin
         step_done_in = 1'b1;
      end
      if (inc) value_in = counter_ff + 1'b1;
      else if (dec) value_in = counter_ff - 1'b1;
      else value_in = counter_ff;
      changed_in = inc || dec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         step_done_ff <= 1'b0;
         counter_ff   <= '0;
      end else if (adv) begin
         mode_ff      <= mode_in;
         step_done_ff <= step_done_in;
         counter_ff   <= value_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/bauc_checker.sv
// Port-level checks for the button autorepeat counter, bound to the top level.
// Depends on bauc_pkg and button_autorepeat_updown_counter_defines.svh.
`default_nettype none

`include "button_autorepeat_updown_counter_defines.svh"

module bauc_checker
   import bauc_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [((VALUE_BITS+8)/8)*8-1:0]   rsp_tdata
);

   logic [VALUE_BITS-1:0] value, last_ff, last_p1, last_m1;
   logic                  changed, req_take, rsp_take;
   logic [1:0]            cnt_ff, cnt_in;

   assign value    = rsp_tdata[VALUE_BITS-1:0];
   assign changed  = rsp_tdata[VALUE_BITS];
   assign req_take = req_tvalid && req_tready;
   assign rsp_take = rsp_tvalid && rsp_tready;
   assign last_p1  = last_ff + 1'b1;
   assign last_m1  = last_ff - 1'b1;
   assign cnt_in   = cnt_ff + 2'(req_take) - 2'(rsp_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (rsp_take) last_ff <= value;
         cnt_ff <= cnt_in;
      end
   end

   `BAUC_ASSERT_ALWAYS(a_idle_after_reset, $past(reset) |-> !rsp_tvalid,
      "response valid right after reset")
   `BAUC_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata),
      "stalled response dropped or changed")
   `BAUC_ASSERT(a_value_kept, rsp_take && !changed |-> value == last_ff,
      "value moved without changed flag")
   `BAUC_ASSERT(a_value_step, rsp_take && changed |-> value == last_p1 || value == last_m1,
      "changed value is not a single step")
   `BAUC_ASSERT(a_no_orphan_rsp, rsp_tvalid |-> cnt_ff != 2'd0,
      "response without a pending request")

endmodule

bind button_autorepeat_updown_counter bauc_checker #(.VALUE_BITS(VALUE_BITS)) u_bauc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
